// ===== rtl/cnsw_pkg.sv =====
package cnsw_pkg;

    // Field and datapath widths.
    localparam int RAD_W      = 24;
    localparam int D2S_W      = 48;
    localparam int INV_W      = 32;
    localparam int CFG_W      = 32;
    localparam int VAL_W      = 31;
    localparam int DER_W      = 32;
    localparam int T_W        = 31;
    localparam int PROD_W     = 56;
    localparam int SUM_W      = 52;
    localparam int SMAG_W     = 32;
    localparam int MAG_W      = 64;
    localparam int NUM_W      = 42;
    localparam int QUO_W      = 32;
    localparam int SQ_REM_W   = 25;
    localparam int VC_W       = 16;
    localparam int DC_W       = 19;
    localparam int MAX_TERMS  = 7;

    // Pipeline depths.
    localparam int SQ_STAGES  = 12;
    localparam int DIV_STAGES = 16;
    localparam int PW_STAGES  = 13;

    localparam logic [VAL_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic signed [SUM_W-1:0] SUM_LIMIT = 52'sh0_0000_FFFF_FFFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SWITCH_ON = 2'd0;
    localparam logic [1:0] CFG_OUTER     = 2'd1;
    localparam logic [1:0] CFG_INV_RANGE = 2'd2;
    localparam logic [1:0] CFG_ORDER     = 2'd3;

    // Smoothness codes.
    localparam logic [1:0] ORDER_2 = 2'd0;
    localparam logic [1:0] ORDER_3 = 2'd1;
    localparam logic [1:0] ORDER_4 = 2'd2;
    localparam logic [1:0] ORDER_6 = 2'd3;

    // Region of a distance relative to the two radii.
    typedef enum logic [1:0] {
        CLS_BAND = 2'd0,
        CLS_OUT  = 2'd1,
        CLS_IN   = 2'd2
    } cls_t;

    // Side information that rides along the divider.
    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic             neg;
        cls_t             cls;
    } div_tag_t;

    localparam logic signed [VC_W-1:0] VAL_COEF [4][MAX_TERMS] = '{
        '{16'sd10, -16'sd15, 16'sd6, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd35, -16'sd84, 16'sd70, -16'sd20, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd126, -16'sd420, 16'sd540, -16'sd315, 16'sd70, 16'sd0, 16'sd0},
        '{16'sd1716, -16'sd9009, 16'sd20020, -16'sd24024, 16'sd16380,
          -16'sd6006, 16'sd924}
    };

    localparam logic signed [DC_W-1:0] DER_COEF [4][MAX_TERMS] = '{
        '{19'sd30, -19'sd60, 19'sd30, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
        '{19'sd140, -19'sd420, 19'sd420, -19'sd140, 19'sd0, 19'sd0, 19'sd0},
        '{19'sd630, -19'sd2520, 19'sd3780, -19'sd2520, 19'sd630, 19'sd0, 19'sd0},
        '{19'sd12012, -19'sd72072, 19'sd180180, -19'sd240240, 19'sd180180,
          -19'sd72072, 19'sd12012}
    };

    // Polynomial order for a smoothness code.
    function automatic int order_n(input logic [1:0] mode);
        int n;
        case (mode)
            ORDER_2: n = 2;
            ORDER_3: n = 3;
            ORDER_4: n = 4;
            default: n = 6;
        endcase
        return n;
    endfunction

    // Value coefficient that multiplies t^k, zero when t^k is not used.
    function automatic logic signed [VC_W-1:0] vcoef(input logic [1:0] mode, input int k);
        int                      idx;
        logic signed [VC_W-1:0]  c;
        idx = k - order_n(mode) - 1;
        c   = '0;
        if (idx >= 0 && idx < MAX_TERMS)
        begin
            c = VAL_COEF[mode][idx[2:0]];
        end
        return c;
    endfunction

    // Derivative coefficient that multiplies t^k, zero when t^k is not used.
    function automatic logic signed [DC_W-1:0] dcoef(input logic [1:0] mode, input int k);
        int                      idx;
        logic signed [DC_W-1:0]  c;
        idx = k - order_n(mode);
        c   = '0;
        if (idx >= 0 && idx < MAX_TERMS)
        begin
            c = DER_COEF[mode][idx[2:0]];
        end
        return c;
    endfunction

endpackage

// ===== rtl/cnsw_sqrt.sv =====
// Pipelined integer square root, a fixed number of root bits per stage.
module cnsw_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [cnsw_pkg::D2S_W-1:0]    in_x,
    input  cnsw_pkg::cls_t                in_tag,
    output logic                          out_valid,
    output logic [cnsw_pkg::RAD_W-1:0]    out_root,
    output cnsw_pkg::cls_t                out_tag
);

    localparam int STEPS = cnsw_pkg::RAD_W / cnsw_pkg::SQ_STAGES;

    typedef struct packed {
        logic [cnsw_pkg::RAD_W-1:0]    root;
        logic [cnsw_pkg::SQ_REM_W-1:0] rem;
    } sq_t;

    logic                          v_reg    [cnsw_pkg::SQ_STAGES];
    logic [cnsw_pkg::D2S_W-1:0]    x_reg    [cnsw_pkg::SQ_STAGES];
    sq_t                           st_reg   [cnsw_pkg::SQ_STAGES];
    cnsw_pkg::cls_t                tag_reg  [cnsw_pkg::SQ_STAGES];
    logic [cnsw_pkg::D2S_W-1:0]    x_next   [cnsw_pkg::SQ_STAGES];
    sq_t                           st_next  [cnsw_pkg::SQ_STAGES];

    // One digit of the restoring square root: bring down two radicand bits.
    function automatic sq_t sq_step(input sq_t cur, input logic [1:0] bits);
        logic [cnsw_pkg::SQ_REM_W+1:0] r2;
        logic [cnsw_pkg::SQ_REM_W+1:0] tr;
        sq_t                           nx;
        r2 = {cur.rem, bits};
        tr = {1'b0, cur.root, 2'b01};
        if (r2 >= tr)
        begin
            nx.rem  = cnsw_pkg::SQ_REM_W'(r2 - tr);
            nx.root = {cur.root[cnsw_pkg::RAD_W-2:0], 1'b1};
        end
        else
        begin
            nx.rem  = r2[cnsw_pkg::SQ_REM_W-1:0];
            nx.root = {cur.root[cnsw_pkg::RAD_W-2:0], 1'b0};
        end
        return nx;
    endfunction

    // Each stage consumes the top radicand bits and shifts them out.
    always_comb
    begin
        for (int s = 0; s < cnsw_pkg::SQ_STAGES; s++)
        begin
            if (s == 0)
            begin
                x_next[s]  = in_x;
                st_next[s] = '0;
            end
            else
            begin
                x_next[s]  = x_reg[s-1];
                st_next[s] = st_reg[s-1];
            end
            for (int k = 0; k < STEPS; k++)
            begin
                st_next[s] = sq_step(st_next[s], x_next[s][cnsw_pkg::D2S_W-1 -: 2]);
                x_next[s]  = {x_next[s][cnsw_pkg::D2S_W-3:0], 2'b00};
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < cnsw_pkg::SQ_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < cnsw_pkg::SQ_STAGES; s++)
            begin
                v_reg[s] <= (s == 0) ? in_valid : v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < cnsw_pkg::SQ_STAGES; s++)
            begin
                x_reg[s]   <= x_next[s];
                st_reg[s]  <= st_next[s];
                tag_reg[s] <= (s == 0) ? in_tag : tag_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[cnsw_pkg::SQ_STAGES-1];
    assign out_root  = st_reg[cnsw_pkg::SQ_STAGES-1].root;
    assign out_tag   = tag_reg[cnsw_pkg::SQ_STAGES-1];

endmodule

// ===== rtl/cnsw_div.sv =====
// Pipelined restoring divider with a 32-bit quotient and an overflow flag.
module cnsw_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [cnsw_pkg::NUM_W-1:0]    in_num,
    input  logic [cnsw_pkg::RAD_W-1:0]    in_den,
    input  cnsw_pkg::div_tag_t            in_tag,
    output logic                          out_valid,
    output logic [cnsw_pkg::QUO_W-1:0]    out_quo,
    output logic                          out_ovf,
    output cnsw_pkg::div_tag_t            out_tag
);

    localparam int STEPS = cnsw_pkg::QUO_W / cnsw_pkg::DIV_STAGES;
    localparam int HI_W  = cnsw_pkg::NUM_W - cnsw_pkg::QUO_W;

    logic                          v_reg    [cnsw_pkg::DIV_STAGES];
    logic [cnsw_pkg::QUO_W-1:0]    n_reg    [cnsw_pkg::DIV_STAGES];
    logic [cnsw_pkg::QUO_W-1:0]    q_reg    [cnsw_pkg::DIV_STAGES];
    logic [cnsw_pkg::RAD_W-1:0]    rem_reg  [cnsw_pkg::DIV_STAGES];
    logic [cnsw_pkg::RAD_W-1:0]    den_reg  [cnsw_pkg::DIV_STAGES];
    logic                          ovf_reg  [cnsw_pkg::DIV_STAGES];
    cnsw_pkg::div_tag_t            tag_reg  [cnsw_pkg::DIV_STAGES];
    logic [cnsw_pkg::QUO_W-1:0]    n_next   [cnsw_pkg::DIV_STAGES];
    logic [cnsw_pkg::QUO_W-1:0]    q_next   [cnsw_pkg::DIV_STAGES];
    logic [cnsw_pkg::RAD_W-1:0]    rem_next [cnsw_pkg::DIV_STAGES];
    logic [cnsw_pkg::RAD_W-1:0]    den_cur  [cnsw_pkg::DIV_STAGES];
    logic [cnsw_pkg::RAD_W:0]      r2       [cnsw_pkg::DIV_STAGES];
    logic                          in_ovf;

    // The quotient fits 32 bits only when the high numerator bits are below the divisor.
    assign in_ovf = ({{(cnsw_pkg::RAD_W-HI_W){1'b0}}, in_num[cnsw_pkg::NUM_W-1 -: HI_W]}
                     >= in_den);

    always_comb
    begin
        for (int s = 0; s < cnsw_pkg::DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                n_next[s]   = in_num[cnsw_pkg::QUO_W-1:0];
                q_next[s]   = '0;
                rem_next[s] = in_ovf ? '0 : cnsw_pkg::RAD_W'(in_num[cnsw_pkg::NUM_W-1 -: HI_W]);
                den_cur[s]  = in_den;
            end
            else
            begin
                n_next[s]   = n_reg[s-1];
                q_next[s]   = q_reg[s-1];
                rem_next[s] = rem_reg[s-1];
                den_cur[s]  = den_reg[s-1];
            end
            r2[s] = '0;
            for (int k = 0; k < STEPS; k++)
            begin
                r2[s]     = {rem_next[s], n_next[s][cnsw_pkg::QUO_W-1]};
                n_next[s] = {n_next[s][cnsw_pkg::QUO_W-2:0], 1'b0};
                if (r2[s] >= {1'b0, den_cur[s]})
                begin
                    r2[s]     = r2[s] - {1'b0, den_cur[s]};
                    q_next[s] = {q_next[s][cnsw_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    q_next[s] = {q_next[s][cnsw_pkg::QUO_W-2:0], 1'b0};
                end
                rem_next[s] = r2[s][cnsw_pkg::RAD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < cnsw_pkg::DIV_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < cnsw_pkg::DIV_STAGES; s++)
            begin
                v_reg[s] <= (s == 0) ? in_valid : v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < cnsw_pkg::DIV_STAGES; s++)
            begin
                n_reg[s]   <= n_next[s];
                q_reg[s]   <= q_next[s];
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_cur[s];
                ovf_reg[s] <= (s == 0) ? in_ovf : ovf_reg[s-1];
                tag_reg[s] <= (s == 0) ? in_tag : tag_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[cnsw_pkg::DIV_STAGES-1];
    assign out_quo   = q_reg[cnsw_pkg::DIV_STAGES-1];
    assign out_ovf   = ovf_reg[cnsw_pkg::DIV_STAGES-1];
    assign out_tag   = tag_reg[cnsw_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/cn_switching_function_eval_core.sv =====
// Smoothstep cutoff switching function for pair distances.
// Input channel: in_valid / in_stall with dist_squared (unsigned Q16.16). A word is
// taken at a clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with switch_value (Q1.30) and switch_deriv
// (signed Q16.16). Exactly one result word is produced for each input word, in order.
// Throughput is one word per cycle while in_stall is low. The pipeline depth comes
// from the 12-stage square root, the 13-stage power chain and the 16-stage divider,
// with the front, gap, product, sum, clamp and numerator stages in between.
// Configuration is written through cfg_write / cfg_index / cfg_data while the block
// holds no work; the squared radii are registered again from the written radii.
// Reset clears all valid bits and the configuration registers; no result is shown
// until a new input arrives.
// When the receiver stalls, the waiting result holds and one more result is parked
// in a skid register; only then is in_stall raised and the whole pipeline frozen.
module cn_switching_function_eval_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [cnsw_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [31:0]                   dist_squared,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cnsw_pkg::VAL_W-1:0]    switch_value,
    output logic signed [cnsw_pkg::DER_W-1:0] switch_deriv
);

    localparam int PWS = cnsw_pkg::PW_STAGES;

    typedef struct packed {
        logic [cnsw_pkg::VAL_W-1:0] val;
        logic [cnsw_pkg::DER_W-1:0] der;
    } out_word_t;

    // Configuration and derived constants.
    logic [cnsw_pkg::RAD_W-1:0]    on_radius_reg;
    logic [cnsw_pkg::RAD_W-1:0]    outer_radius_reg;
    logic [cnsw_pkg::INV_W-1:0]    inv_range_reg;
    logic [1:0]                    order_mode_reg;
    logic [cnsw_pkg::D2S_W-1:0]    osq_reg;
    logic [cnsw_pkg::D2S_W-1:0]    isq_reg;
    logic                          inv_neg;
    logic [cnsw_pkg::INV_W-1:0]    inv_mag;

    logic                          run;

    // Front stage and region test.
    logic                          s0_v_reg;
    logic [cnsw_pkg::D2S_W-1:0]    s0_d2s_reg;
    cnsw_pkg::cls_t                s0_cls;

    logic                          sq_v;
    logic [cnsw_pkg::RAD_W-1:0]    sq_root;
    cnsw_pkg::cls_t                sq_cls;

    logic                          a_v_reg;
    logic [cnsw_pkg::RAD_W-1:0]    a_r_reg;
    logic [cnsw_pkg::RAD_W-1:0]    a_gap_reg;
    cnsw_pkg::cls_t                a_cls_reg;

    logic                          b_v_reg;
    logic [cnsw_pkg::RAD_W-1:0]    b_r_reg;
    logic [cnsw_pkg::PROD_W-1:0]   b_prod_reg;
    cnsw_pkg::cls_t                b_cls_reg;
    logic [cnsw_pkg::PROD_W:0]     b_round;
    logic [cnsw_pkg::T_W-1:0]      b_t;

    // Power chain: stage j holds t^(j+1) and the sums over lower powers.
    logic                              p_v_reg    [PWS];
    logic [cnsw_pkg::T_W-1:0]          p_t_reg    [PWS];
    logic [cnsw_pkg::T_W-1:0]          p_pw_reg   [PWS];
    logic signed [cnsw_pkg::SUM_W-1:0] p_vsum_reg [PWS];
    logic signed [cnsw_pkg::SUM_W-1:0] p_ssum_reg [PWS];
    logic [cnsw_pkg::RAD_W-1:0]        p_r_reg    [PWS];
    cnsw_pkg::cls_t                    p_cls_reg  [PWS];
    logic [cnsw_pkg::T_W-1:0]          p_pw_next  [PWS-1];
    logic signed [cnsw_pkg::SUM_W-1:0] p_vsum_next[PWS];
    logic signed [cnsw_pkg::SUM_W-1:0] p_ssum_next[PWS];
    logic [2*cnsw_pkg::T_W-1:0]        p_prod     [PWS-1];
    logic signed [cnsw_pkg::VC_W+cnsw_pkg::T_W:0] p_vterm [PWS];
    logic signed [cnsw_pkg::DC_W+cnsw_pkg::T_W:0] p_dterm [PWS];

    logic                              f_v_reg;
    logic signed [cnsw_pkg::SUM_W-1:0] f_vsum_reg;
    logic signed [cnsw_pkg::SUM_W-1:0] f_ssum_reg;
    logic [cnsw_pkg::RAD_W-1:0]        f_r_reg;
    cnsw_pkg::cls_t                    f_cls_reg;

    logic signed [cnsw_pkg::SUM_W-1:0] g_sclamp;
    logic signed [cnsw_pkg::SUM_W-1:0] g_sabs;
    logic                              g_v_reg;
    logic [cnsw_pkg::VAL_W-1:0]        g_val_reg;
    logic [cnsw_pkg::SMAG_W-1:0]       g_smag_reg;
    logic                              g_neg_reg;
    logic [cnsw_pkg::RAD_W-1:0]        g_rr_reg;
    cnsw_pkg::cls_t                    g_cls_reg;

    logic                              h_v_reg;
    logic [cnsw_pkg::MAG_W-1:0]        h_mag_reg;
    logic [cnsw_pkg::RAD_W-1:0]        h_rr_reg;
    cnsw_pkg::div_tag_t                h_tag_reg;

    logic                              dv_v;
    logic [cnsw_pkg::QUO_W-1:0]        dv_quo;
    logic                              dv_ovf;
    cnsw_pkg::div_tag_t                dv_tag;

    out_word_t                         pipe_word;
    logic [cnsw_pkg::DER_W-1:0]        sat_mag;
    logic                              out_v_reg;
    logic                              skid_v_reg;
    out_word_t                         out_reg;
    out_word_t                         skid_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_radius_reg    <= '0;
            outer_radius_reg <= '0;
            inv_range_reg    <= '0;
            order_mode_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cnsw_pkg::CFG_SWITCH_ON: on_radius_reg    <= cfg_data[cnsw_pkg::RAD_W-1:0];
                cnsw_pkg::CFG_OUTER:     outer_radius_reg <= cfg_data[cnsw_pkg::RAD_W-1:0];
                cnsw_pkg::CFG_INV_RANGE: inv_range_reg    <= cfg_data[cnsw_pkg::INV_W-1:0];
                cnsw_pkg::CFG_ORDER:     order_mode_reg   <= cfg_data[1:0];
                default:                 order_mode_reg   <= order_mode_reg;
            endcase
        end
    end

    // Squared radii for the region compare.
    always_ff @(posedge clk)
    begin
        osq_reg <= outer_radius_reg * outer_radius_reg;
        isq_reg <= on_radius_reg * on_radius_reg;
    end

    assign inv_neg = inv_range_reg[cnsw_pkg::INV_W-1];
    assign inv_mag = inv_neg ? (~inv_range_reg + 1'b1) : inv_range_reg;

    // The pipeline moves unless the skid register is occupied.
    assign run      = !skid_v_reg;
    assign in_stall = !run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (run)
        begin
            s0_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            s0_d2s_reg <= {dist_squared, 16'h0000};
        end
    end

    // Cutoff test comes before the switch-on test.
    always_comb
    begin
        if (s0_d2s_reg > osq_reg)
        begin
            s0_cls = cnsw_pkg::CLS_OUT;
        end
        else if (s0_d2s_reg < isq_reg)
        begin
            s0_cls = cnsw_pkg::CLS_IN;
        end
        else
        begin
            s0_cls = cnsw_pkg::CLS_BAND;
        end
    end

    cnsw_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (run),
        .in_valid  (s0_v_reg),
        .in_x      (s0_d2s_reg),
        .in_tag    (s0_cls),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_tag   (sq_cls)
    );

    // Scaled t with rounding, clamped to one, forced to zero for a non-negative range factor.
    assign b_round = {1'b0, b_prod_reg} + (cnsw_pkg::PROD_W+1)'(512);

    always_comb
    begin
        if (!inv_neg)
        begin
            b_t = '0;
        end
        else if (b_round[cnsw_pkg::PROD_W:10] > (cnsw_pkg::PROD_W-9)'(cnsw_pkg::ONE_Q30))
        begin
            b_t = cnsw_pkg::ONE_Q30;
        end
        else
        begin
            b_t = b_round[10 +: cnsw_pkg::T_W];
        end
    end

    // Next power of t with rounding, and the coefficient terms of this power.
    always_comb
    begin
        for (int j = 0; j < PWS; j++)
        begin
            p_vterm[j] = cnsw_pkg::vcoef(order_mode_reg, j + 1)
                         * $signed({1'b0, p_pw_reg[j]});
            p_dterm[j] = cnsw_pkg::dcoef(order_mode_reg, j + 1)
                         * $signed({1'b0, p_pw_reg[j]});
            p_vsum_next[j] = p_vsum_reg[j] + cnsw_pkg::SUM_W'(p_vterm[j]);
            p_ssum_next[j] = p_ssum_reg[j] + cnsw_pkg::SUM_W'(p_dterm[j]);
        end
        for (int j = 0; j < PWS - 1; j++)
        begin
            p_prod[j]    = p_pw_reg[j] * p_t_reg[j] + (2*cnsw_pkg::T_W)'(1 << 29);
            p_pw_next[j] = p_prod[j][30 +: cnsw_pkg::T_W];
        end
    end

    // Clamp of the derivative sum and its magnitude.
    always_comb
    begin
        if (f_ssum_reg > cnsw_pkg::SUM_LIMIT)
        begin
            g_sclamp = cnsw_pkg::SUM_LIMIT;
        end
        else if (f_ssum_reg < -cnsw_pkg::SUM_LIMIT)
        begin
            g_sclamp = -cnsw_pkg::SUM_LIMIT;
        end
        else
        begin
            g_sclamp = f_ssum_reg;
        end
        g_sabs = g_sclamp[cnsw_pkg::SUM_W-1] ? -g_sclamp : g_sclamp;
    end

    // Valid bits of the middle stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            for (int j = 0; j < PWS; j++)
            begin
                p_v_reg[j] <= 1'b0;
            end
        end
        else if (run)
        begin
            a_v_reg <= sq_v;
            b_v_reg <= a_v_reg;
            for (int j = 0; j < PWS; j++)
            begin
                p_v_reg[j] <= (j == 0) ? b_v_reg : p_v_reg[j-1];
            end
            f_v_reg <= p_v_reg[PWS-1];
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
        end
    end

    // Middle stage payload.
    always_ff @(posedge clk)
    begin
        if (run)
        begin
            // Gap below the cutoff radius.
            a_r_reg   <= sq_root;
            a_gap_reg <= (sq_root < outer_radius_reg) ? (outer_radius_reg - sq_root) : '0;
            a_cls_reg <= sq_cls;

            // Gap times range factor.
            b_r_reg    <= a_r_reg;
            b_prod_reg <= a_gap_reg * inv_mag;
            b_cls_reg  <= a_cls_reg;

            // Power chain.
            p_t_reg[0]    <= b_t;
            p_pw_reg[0]   <= b_t;
            p_vsum_reg[0] <= '0;
            p_ssum_reg[0] <= '0;
            p_r_reg[0]    <= b_r_reg;
            p_cls_reg[0]  <= b_cls_reg;
            for (int j = 1; j < PWS; j++)
            begin
                p_t_reg[j]    <= p_t_reg[j-1];
                p_pw_reg[j]   <= p_pw_next[j-1];
                p_vsum_reg[j] <= p_vsum_next[j-1];
                p_ssum_reg[j] <= p_ssum_next[j-1];
                p_r_reg[j]    <= p_r_reg[j-1];
                p_cls_reg[j]  <= p_cls_reg[j-1];
            end

            f_vsum_reg <= p_vsum_next[PWS-1];
            f_ssum_reg <= p_ssum_next[PWS-1];
            f_r_reg    <= p_r_reg[PWS-1];
            f_cls_reg  <= p_cls_reg[PWS-1];

            // Value clamp and derivative sign.
            if (f_vsum_reg[cnsw_pkg::SUM_W-1])
            begin
                g_val_reg <= '0;
            end
            else if (f_vsum_reg > cnsw_pkg::SUM_W'(cnsw_pkg::ONE_Q30))
            begin
                g_val_reg <= cnsw_pkg::ONE_Q30;
            end
            else
            begin
                g_val_reg <= f_vsum_reg[cnsw_pkg::VAL_W-1:0];
            end
            g_smag_reg <= g_sabs[cnsw_pkg::SMAG_W-1:0];
            g_neg_reg  <= g_sclamp[cnsw_pkg::SUM_W-1] != inv_neg;
            g_rr_reg   <= (f_r_reg == '0) ? cnsw_pkg::RAD_W'(1) : f_r_reg;
            g_cls_reg  <= f_cls_reg;

            // Derivative numerator.
            h_mag_reg     <= g_smag_reg * inv_mag;
            h_rr_reg      <= g_rr_reg;
            h_tag_reg.val <= g_val_reg;
            h_tag_reg.neg <= g_neg_reg;
            h_tag_reg.cls <= g_cls_reg;
        end
    end

    // Dividing by r * 2^22 equals dividing the numerator shifted down by 22 by r.
    cnsw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (run),
        .in_valid  (h_v_reg),
        .in_num    (h_mag_reg[cnsw_pkg::MAG_W-1 -: cnsw_pkg::NUM_W]),
        .in_den    (h_rr_reg),
        .in_tag    (h_tag_reg),
        .out_valid (dv_v),
        .out_quo   (dv_quo),
        .out_ovf   (dv_ovf),
        .out_tag   (dv_tag)
    );

    // Saturate the quotient and assemble the result word.
    always_comb
    begin
        if (dv_tag.neg)
        begin
            sat_mag = (dv_ovf || dv_quo > 32'h8000_0000) ? 32'h8000_0000 : dv_quo;
        end
        else
        begin
            sat_mag = (dv_ovf || dv_quo[cnsw_pkg::QUO_W-1]) ? 32'h7FFF_FFFF : dv_quo;
        end
        case (dv_tag.cls)
            cnsw_pkg::CLS_OUT:
            begin
                pipe_word.val = '0;
                pipe_word.der = '0;
            end
            cnsw_pkg::CLS_IN:
            begin
                pipe_word.val = cnsw_pkg::ONE_Q30;
                pipe_word.der = '0;
            end
            default:
            begin
                pipe_word.val = dv_tag.val;
                pipe_word.der = dv_tag.neg ? (~sat_mag + 1'b1) : sat_mag;
            end
        endcase
    end

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_v_reg && out_stall)
        begin
            if (run && dv_v)
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (skid_v_reg)
        begin
            out_v_reg  <= 1'b1;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= run && dv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_v_reg && out_stall)
        begin
            if (run && dv_v)
            begin
                skid_reg <= pipe_word;
            end
        end
        else if (skid_v_reg)
        begin
            out_reg <= skid_reg;
        end
        else
        begin
            out_reg <= pipe_word;
        end
    end

    assign out_valid    = out_v_reg;
    assign switch_value = out_reg.val;
    assign switch_deriv = out_reg.der;

endmodule

// ===== rtl/cnsw_checker.sv =====
// Port-level checks of the switching function core.
module cnsw_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [cnsw_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [31:0]                   dist_squared,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [cnsw_pkg::VAL_W-1:0]    switch_value,
    input  logic signed [cnsw_pkg::DER_W-1:0] switch_deriv
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(switch_value)
                                   && $stable(switch_deriv))
        else $error("stalled result word changed");

    // The switching value never exceeds one.
    a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> switch_value <= cnsw_pkg::ONE_Q30)
        else $error("switching value above one");

    // Input back-pressure only exists while a result is waiting.
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result pending");

    // Input back-pressure only follows a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_stall))
        else $error("input stalled without output stall");

endmodule

bind cn_switching_function_eval_core cnsw_checker u_cnsw_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int ITEMS_RANDOM = 1128;

    // One result word as the block presents it.
    typedef struct packed {
        logic [cnsw_pkg::VAL_W-1:0]        value;
        logic signed [cnsw_pkg::DER_W-1:0] deriv;
    } switch_word_t;

    // Expected results waiting for the output side, with failure count.
    class switch_scoreboard;
        switch_word_t pending[$];
        int           fails;

        function void note_word(switch_word_t w);
            pending.insert(pending.size(), w);
        endfunction

        task check_word(switch_word_t got);
            switch_word_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result word with nothing expected", 0, got.value);
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value)
                report_mismatch("switch_value", want.value, got.value);
            if (got.deriv !== want.deriv)
                report_mismatch("switch_deriv", want.deriv, got.deriv);
        endtask

        task report_mismatch(string what, longint want, longint got);
            $display("mismatch %s: expected %0h got %0h", what, want, got);
            fails++;
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_write = 1'b0;
    logic [1:0]                        cfg_index = cnsw_pkg::CFG_SWITCH_ON;
    logic [cnsw_pkg::CFG_W-1:0]        cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [31:0]                       dist_squared = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [cnsw_pkg::VAL_W-1:0]        switch_value;
    logic signed [cnsw_pkg::DER_W-1:0] switch_deriv;

    switch_scoreboard sb = new();

    // Copy of the configuration kept by the testbench.
    logic [23:0]             on_rad, out_rad;
    logic signed [31:0]      inv_rng;
    logic [1:0]              order_sel;
    int                      send_idle, recv_idle;

    cn_switching_function_eval_core DUT (.*);

    always #2 clk = ~clk;

    // Integer square root, floor.
    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Predicts the switching value and derivative for one squared distance.
    function automatic switch_word_t predict_switch(logic [31:0] d2);
        logic [63:0]  d2s, r, gap, inv_mag, t, smag, mag, den, q;
        logic [63:0]  pw [14];
        longint       vsum, ssum;
        longint       slim;
        int           n;
        logic         neg;
        switch_word_t w;
        d2s = {32'd0, d2} << 16;
        w.value = '0;
        w.deriv = '0;
        slim = (longint'(1) << 32) - 1;
        if (d2s > 64'(out_rad) * 64'(out_rad))
            return w;
        if (d2s < 64'(on_rad) * 64'(on_rad))
        begin
            w.value = cnsw_pkg::ONE_Q30;
            return w;
        end
        r = floor_sqrt(d2s);
        gap = (r < out_rad) ? 64'(out_rad) - r : 0;
        inv_mag = (inv_rng < 0) ? 64'(-longint'(inv_rng)) : 64'(longint'(inv_rng));
        t = 0;
        if (inv_rng < 0)
        begin
            t = (gap * inv_mag + 512) >> 10;
            if (t > 64'd1 << 30)
                t = 64'd1 << 30;
        end
        pw[0] = 64'd1 << 30;
        for (int i = 1; i < 14; i++)
            pw[i] = (pw[i-1] * t + (64'd1 << 29)) >> 30;
        case (order_sel)
            cnsw_pkg::ORDER_2: n = 2;
            cnsw_pkg::ORDER_3: n = 3;
            cnsw_pkg::ORDER_4: n = 4;
            default:           n = 6;
        endcase
        vsum = 0;
        ssum = 0;
        for (int i = 0; i < n + 1 && i < cnsw_pkg::MAX_TERMS; i++)
        begin
            vsum += longint'(cnsw_pkg::VAL_COEF[order_sel][i]) * longint'(pw[n+1+i]);
            ssum += longint'(cnsw_pkg::DER_COEF[order_sel][i]) * longint'(pw[n+i]);
        end
        if (vsum < 0)
            w.value = '0;
        else if (vsum > longint'(cnsw_pkg::ONE_Q30))
            w.value = cnsw_pkg::ONE_Q30;
        else
            w.value = vsum[cnsw_pkg::VAL_W-1:0];
        if (ssum > slim)
            ssum = slim;
        if (ssum < -slim)
            ssum = -slim;
        neg = (ssum < 0) != (inv_rng < 0);
        smag = (ssum < 0) ? 64'(-ssum) : 64'(ssum);
        mag = smag * inv_mag;
        den = ((r == 0) ? 64'd1 : r) << 22;
        q = mag / den;
        if (neg)
        begin
            if (q > 64'd1 << 31)
                q = 64'd1 << 31;
            w.deriv = 32'(-longint'(q));
        end
        else
        begin
            if (q > (64'd1 << 31) - 1)
                q = (64'd1 << 31) - 1;
            w.deriv = q[31:0];
        end
        return w;
    endfunction

    // Writes one register while the block is idle; the caller drops the enable.
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            cnsw_pkg::CFG_SWITCH_ON: on_rad = data[23:0];
            cnsw_pkg::CFG_OUTER:     out_rad = data[23:0];
            cnsw_pkg::CFG_INV_RANGE: inv_rng = data;
            cnsw_pkg::CFG_ORDER:     order_sel = data[1:0];
            default:                 ;
        endcase
    endtask

    task automatic set_config(logic [23:0] on_r, logic [23:0] out_r, logic [31:0] inv,
                              logic [1:0] ord);
        write_reg(cnsw_pkg::CFG_SWITCH_ON, {8'd0, on_r});
        write_reg(cnsw_pkg::CFG_OUTER, {8'd0, out_r});
        write_reg(cnsw_pkg::CFG_INV_RANGE, inv);
        write_reg(cnsw_pkg::CFG_ORDER, {30'd0, ord});
        cfg_write <= 1'b0;
        repeat (3) @(posedge clk);
    endtask

    // Sends one distance word, with random idle cycles before it.
    task automatic send_word(logic [31:0] d2);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        dist_squared <= d2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(predict_switch(d2));
    endtask

    // Waits until every expected result has been seen.
    task automatic drain;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Receiver: random stalls and result checking.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_word('{switch_value, switch_deriv});
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Picks a distance mostly up to just past the cutoff radius, some near the switch-on radius.
    function automatic logic [31:0] pick_dist();
        logic [63:0] r, sq;
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'($urandom_range(255));
            default:
            begin
                r = $urandom_range(out_rad + 64) ;
                if ($urandom_range(3) == 0)
                    r = $urandom_range(on_rad + 4, on_rad > 4 ? on_rad - 4 : 0);
                sq = (r * r) >> 16;
                sq = sq + $urandom_range(3) - 1;
                return sq[31:0];
            end
        endcase
    endfunction

    initial
    begin
        logic [23:0] o_r, s_r;
        logic [31:0] inv;
        on_rad = 0;
        out_rad = 0;
        inv_rng = 0;
        order_sel = cnsw_pkg::ORDER_2;
        send_idle = 0;
        recv_idle = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: reset config, extremes, every order, special cases.
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        drain();
        set_config(24'h01_0000, 24'h03_0000, -32'sd8388608, cnsw_pkg::ORDER_2);
        send_word(32'd0);
        send_word(32'h0000_FFFF);
        send_word(32'h0004_0000);
        send_word(32'h0009_0000);
        send_word(32'h0009_0001);
        send_word(32'hFFFF_FFFF);
        for (int m = 0; m < 4; m++)
        begin
            drain();
            set_config(24'h01_0000, 24'h03_0000, -32'sd8388608, 2'(m));
            send_word(32'h0002_0000);
            send_word(32'h0006_8000);
        end
        drain();
        // Inconsistent radii, positive inv_range, zero distance in band.
        set_config(24'hFF_FFFF, 24'h00_0000, 32'sd5, cnsw_pkg::ORDER_6);
        send_word(32'd0);
        send_word(32'd1);
        drain();
        set_config(24'h00_0000, 24'hFF_FFFF, 32'h8000_0000, cnsw_pkg::ORDER_6);
        send_word(32'd0);
        send_word(32'h0000_0001);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0000);
        drain();
        set_config(24'h00_0000, 24'hFF_FFFF, 32'h7FFF_FFFF, cnsw_pkg::ORDER_3);
        send_word(32'h1234_5678);
        drain();

        // Random phases, idling pattern changes by third.
        for (int ph = 0; ph < 24; ph++)
        begin
            send_idle = (ph < 8) ? 35 : (ph < 16) ? 81 : 0;
            recv_idle = (ph < 8) ? 81 : (ph < 16) ? 35 : 0;
            o_r = (ph % 6 == 0) ? 24'hFF_FFFF : 24'($urandom_range(24'h08_0000, 24'h100));
            s_r = (ph % 7 == 0) ? 24'd0 : 24'($urandom_range(o_r));
            if (ph % 9 == 4)
                s_r = o_r + 1;
            case (ph % 5)
                0: inv = 32'h8000_0000;
                1: inv = $urandom();
                2: inv = 32'h7FFF_FFFF;
                default:
                    inv = (o_r != s_r && o_r > s_r) ?
                          32'(-((longint'(1) << 40) / (o_r - s_r))) : -32'sd1;
            endcase
            set_config(s_r, o_r, inv, 2'($urandom_range(3)));
            for (int k = 0; k < ITEMS_RANDOM / 24; k++)
                send_word(pick_dist());
            drain();
        end

        if (sb.fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule
